[rtl/core/bmh_pkg.sv]
package bmh_pkg;

   localparam int HEAP_DEPTH = 64;
   localparam int IDX_W      = $clog2(HEAP_DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int KEY_W      = 32;

   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic signed [KEY_W-1:0] key_type;

   typedef enum logic [2:0] {
      KIND_APPEND   = 3'd0,
      KIND_BUILD    = 3'd1,
      KIND_INSERT   = 3'd2,
      KIND_DELETE   = 3'd3,
      KIND_INCREASE = 3'd4,
      KIND_DECREASE = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      kind_type kind;
      key_type  key_value;
      idx_type  position;
   } req_type;

   typedef struct packed {
      status_type status;
      cnt_type    heap_count;
      key_type    top_key;
      key_type    removed_key;
   } rsp_type;

endpackage

[rtl/core/bmh_key_cmp.sv]
// Shared signed key comparator: less is set when a < b.
module bmh_key_cmp (
   input  bmh_pkg::key_type a,
   input  bmh_pkg::key_type b,
   output logic             less
);

   assign less = (a < b);

endmodule

[rtl/core/bmh_sift_ctrl.sv]
// Heap store plus the sequencer that runs every operation through one
// comparator, one memory read and one memory write per cycle.
module bmh_sift_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bmh_pkg::req_type  req,
   output logic              ready,
   input  logic              slot_free,
   output logic              done,
   output bmh_pkg::rsp_type  rsp
);

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_DEL_CAP  = 15'b000000000000010,
      S_DEL_LAST = 15'b000000000000100,
      S_LD_RD    = 15'b000000000001000,
      S_LD       = 15'b000000000010000,
      S_DN_L     = 15'b000000000100000,
      S_DN_R     = 15'b000000001000000,
      S_DN_SEL   = 15'b000000010000000,
      S_DN_DEC   = 15'b000000100000000,
      S_UP_RD    = 15'b000001000000000,
      S_UP_DEC   = 15'b000010000000000,
      S_NEXT     = 15'b000100000000000,
      S_ROOT_RD  = 15'b001000000000000,
      S_ROOT     = 15'b010000000000000,
      S_DONE     = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   bmh_pkg::key_type    heap_ram [bmh_pkg::HEAP_DEPTH];
   bmh_pkg::key_type    rd_data_ff;

   bmh_pkg::cnt_type    count_ff, count_in;
   bmh_pkg::kind_type   op_ff, op_in;
   bmh_pkg::idx_type    pos_ff, pos_in;
   bmh_pkg::idx_type    i_ff, i_in;
   bmh_pkg::idx_type    cidx_ff, cidx_in;
   bmh_pkg::idx_type    ld_addr_ff, ld_addr_in;
   logic                ld_up_ff, ld_up_in;
   logic                phase_ff, phase_in;
   logic                have_r_ff, have_r_in;
   bmh_pkg::key_type    k_ff, k_in;
   bmh_pkg::key_type    lval_ff, lval_in;
   bmh_pkg::key_type    cval_ff, cval_in;
   bmh_pkg::key_type    top_ff, top_in;
   bmh_pkg::key_type    removed_ff, removed_in;
   bmh_pkg::status_type status_ff, status_in;

   logic                mem_we;
   bmh_pkg::idx_type    mem_waddr;
   bmh_pkg::key_type    mem_wdata;
   bmh_pkg::idx_type    mem_raddr;

   bmh_pkg::key_type    cmp_a;
   bmh_pkg::key_type    cmp_b;
   logic                cmp_less;

   logic [bmh_pkg::CNT_W:0] left_w;
   logic [bmh_pkg::CNT_W:0] right_w;
   logic [bmh_pkg::CNT_W:0] count_w;
   bmh_pkg::idx_type        parent_idx;
   bmh_pkg::cnt_type        count_m1;
   bmh_pkg::cnt_type        count_m2;
   logic                    req_pos_ok;

   bmh_key_cmp u_cmp (
      .a    (cmp_a),
      .b    (cmp_b),
      .less (cmp_less)
   );

   assign left_w     = {1'b0, i_ff, 1'b1};
   assign right_w    = {1'b0, i_ff, 1'b0} + (bmh_pkg::CNT_W + 1)'(2);
   assign count_w    = {1'b0, count_ff};
   assign parent_idx = (i_ff - bmh_pkg::IDX_W'(1)) >> 1;
   assign count_m1   = count_ff - bmh_pkg::CNT_W'(1);
   assign count_m2   = count_ff - bmh_pkg::CNT_W'(2);
   assign req_pos_ok = ({1'b0, req.position} < count_ff);

   // comparator operand select
   always_comb begin
      case (state_ff)
         S_DN_SEL: begin
            cmp_a = rd_data_ff;
            cmp_b = lval_ff;
         end
         S_DN_DEC: begin
            cmp_a = cval_ff;
            cmp_b = k_ff;
         end
         default: begin
            cmp_a = k_ff;
            cmp_b = rd_data_ff;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      op_in      = op_ff;
      pos_in     = pos_ff;
      i_in       = i_ff;
      cidx_in    = cidx_ff;
      ld_addr_in = ld_addr_ff;
      ld_up_in   = ld_up_ff;
      phase_in   = phase_ff;
      have_r_in  = have_r_ff;
      k_in       = k_ff;
      lval_in    = lval_ff;
      cval_in    = cval_ff;
      top_in     = top_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      mem_we     = 1'b0;
      mem_waddr  = i_ff;
      mem_wdata  = k_ff;
      mem_raddr  = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = req.kind;
               pos_in     = req.position;
               removed_in = '0;
               status_in  = bmh_pkg::STAT_OK;
               state_in   = S_ROOT_RD;
               case (req.kind)
                  bmh_pkg::KIND_APPEND, bmh_pkg::KIND_INSERT: begin
                     if (count_ff == bmh_pkg::CNT_W'(bmh_pkg::HEAP_DEPTH)) begin
                        status_in = bmh_pkg::STAT_FULL;
                     end else begin
                        count_in = count_ff + bmh_pkg::CNT_W'(1);
                        k_in     = req.key_value;
                        i_in     = count_ff[bmh_pkg::IDX_W-1:0];
                        if (req.kind == bmh_pkg::KIND_INSERT) begin
                           state_in = S_UP_RD;
                        end else begin
                           mem_we    = 1'b1;
                           mem_waddr = count_ff[bmh_pkg::IDX_W-1:0];
                           mem_wdata = req.key_value;
                        end
                     end
                  end
                  bmh_pkg::KIND_BUILD: begin
                     if (count_ff >= bmh_pkg::CNT_W'(2)) begin
                        ld_addr_in = count_m2[bmh_pkg::CNT_W-1:1];
                        ld_up_in   = 1'b0;
                        state_in   = S_LD_RD;
                     end
                  end
                  bmh_pkg::KIND_DELETE: begin
                     if (!req_pos_ok) begin
                        status_in = bmh_pkg::STAT_RANGE;
                     end else begin
                        mem_raddr = req.position;
                        state_in  = S_DEL_CAP;
                     end
                  end
                  bmh_pkg::KIND_INCREASE, bmh_pkg::KIND_DECREASE: begin
                     if (!req_pos_ok) begin
                        status_in = bmh_pkg::STAT_RANGE;
                     end else begin
                        k_in     = req.key_value;
                        i_in     = req.position;
                        state_in = (req.kind == bmh_pkg::KIND_INCREASE) ? S_DN_L : S_UP_RD;
                     end
                  end
                  default: begin
                     state_in = S_ROOT_RD;
                  end
               endcase
            end
         end
         S_DEL_CAP: begin
            removed_in = rd_data_ff;
            count_in   = count_m1;
            if ({1'b0, pos_ff} != count_m1) begin
               // pull the last key into the hole
               mem_raddr = count_m1[bmh_pkg::IDX_W-1:0];
               state_in  = S_DEL_LAST;
            end else begin
               state_in = S_ROOT_RD;
            end
         end
         S_DEL_LAST: begin
            k_in     = rd_data_ff;
            i_in     = pos_ff;
            phase_in = 1'b0;
            state_in = S_DN_L;
         end
         S_LD_RD: begin
            mem_raddr = ld_addr_ff;
            state_in  = S_LD;
         end
         S_LD: begin
            k_in     = rd_data_ff;
            i_in     = ld_addr_ff;
            state_in = ld_up_ff ? S_UP_RD : S_DN_L;
         end
         S_DN_L: begin
            if (left_w >= count_w) begin
               mem_we   = 1'b1;
               state_in = S_NEXT;
            end else begin
               mem_raddr = left_w[bmh_pkg::IDX_W-1:0];
               state_in  = S_DN_R;
            end
         end
         S_DN_R: begin
            lval_in = rd_data_ff;
            if (right_w < count_w) begin
               mem_raddr = right_w[bmh_pkg::IDX_W-1:0];
               have_r_in = 1'b1;
            end else begin
               have_r_in = 1'b0;
            end
            state_in = S_DN_SEL;
         end
         S_DN_SEL: begin
            // right child wins only when strictly smaller
            if (have_r_ff && cmp_less) begin
               cval_in = rd_data_ff;
               cidx_in = right_w[bmh_pkg::IDX_W-1:0];
            end else begin
               cval_in = lval_ff;
               cidx_in = left_w[bmh_pkg::IDX_W-1:0];
            end
            state_in = S_DN_DEC;
         end
         S_DN_DEC: begin
            mem_we = 1'b1;
            if (cmp_less) begin
               mem_wdata = cval_ff;
               i_in      = cidx_ff;
               state_in  = S_DN_L;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_UP_RD: begin
            if (i_ff == '0) begin
               mem_we   = 1'b1;
               state_in = S_NEXT;
            end else begin
               mem_raddr = parent_idx;
               state_in  = S_UP_DEC;
            end
         end
         S_UP_DEC: begin
            mem_we = 1'b1;
            if (cmp_less) begin
               mem_wdata = rd_data_ff;
               i_in      = parent_idx;
               state_in  = S_UP_RD;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            state_in = S_ROOT_RD;
            if (op_ff == bmh_pkg::KIND_BUILD) begin
               if (ld_addr_ff != '0) begin
                  ld_addr_in = ld_addr_ff - bmh_pkg::IDX_W'(1);
                  ld_up_in   = 1'b0;
                  state_in   = S_LD_RD;
               end
            end else if (op_ff == bmh_pkg::KIND_DELETE && !phase_ff) begin
               // second pass of delete: sift up from the same slot
               phase_in   = 1'b1;
               ld_addr_in = pos_ff;
               ld_up_in   = 1'b1;
               state_in   = S_LD_RD;
            end
         end
         S_ROOT_RD: begin
            mem_raddr = '0;
            state_in  = S_ROOT;
         end
         S_ROOT: begin
            top_in   = (count_ff != '0) ? rd_data_ff : '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_ram[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= heap_ram[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pos_ff     <= pos_in;
      i_ff       <= i_in;
      cidx_ff    <= cidx_in;
      ld_addr_ff <= ld_addr_in;
      ld_up_ff   <= ld_up_in;
      phase_ff   <= phase_in;
      have_r_ff  <= have_r_in;
      k_ff       <= k_in;
      lval_ff    <= lval_in;
      cval_ff    <= cval_in;
      top_ff     <= top_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   assign ready           = (state_ff == S_IDLE);
   assign done            = (state_ff == S_DONE);
   assign rsp.status      = status_ff;
   assign rsp.heap_count  = count_ff;
   assign rsp.top_key     = top_ff;
   assign rsp.removed_key = removed_ff;

endmodule

[rtl/core/binary_min_heap_engine.sv]
// Binary min-heap engine: holds up to 64 signed 32-bit keys in an on-chip
// store and runs one heap operation per request (append raw, build, insert,
// delete at slot, increase key, decrease key), answering every request with
// exactly one response carrying status, key count, root key and removed key.
// Requests are taken one at a time: req_tready stays low from acceptance
// until the response has moved into the output register. The cost is set by
// the heap store's one read and one write port and the one shared key
// comparator: a sift-down reads the left child, reads the right child,
// picks the smaller child, then compares it with the key and writes at each
// tree level it moves; a sift-up reads the parent, compares and writes at
// each level. Every request passes through acceptance, root readback and
// handoff to the output register, and a sifting request through one more
// step between sift and readback. Delete runs a sift-down and then a sift-up
// from the same slot; build runs one sift-down per parent, from the last
// parent back to the root.
// Keys in slots never written read as undefined, but no operation uses a key
// beyond the current count, so no clearing pass runs after reset.
module binary_min_heap_engine (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] key_value, [37:32] position, [39:38] zero
   input  logic [2:0]  req_tuser,   // [2:0] kind

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [6:0] heap_count, [38:7] top_key,
                                    // [70:39] removed_key, [71] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   bmh_pkg::req_type req;
   bmh_pkg::rsp_type core_rsp;
   bmh_pkg::rsp_type rsp_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             core_ready;
   logic             core_done;
   logic             slot_free;
   logic             start;

   // unpack the request
   assign req.kind      = bmh_pkg::kind_type'(req_tuser);
   assign req.key_value = req_tdata[31:0];
   assign req.position  = req_tdata[37:32];

   assign req_tready = core_ready;
   assign start      = req_tvalid && core_ready;

   // output slot frees up when empty or drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   bmh_sift_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .ready     (core_ready),
      .slot_free (slot_free),
      .done      (core_done),
      .rsp       (core_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_done && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the response until the sink takes it
   always_ff @(posedge clock) begin
      if (core_done && slot_free) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {1'b0, rsp_data_ff.removed_key, rsp_data_ff.top_key,
                        rsp_data_ff.heap_count};

endmodule

[bench/tb_binary_min_heap_engine.sv]
`timescale 1ns / 100ps

module tb_binary_min_heap_engine;
   import bmh_pkg::*;

   // kinds 6 and 7 are not part of kind_type; the block must answer them with no change
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   localparam int REQUEST_GOAL = 1600;
   localparam int SETTLE_CYCLES = 50;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [31:0] key_value, [37:32] position, [39:38] zero
   logic [2:0]  req_tuser = '0;   // [2:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // [6:0] heap_count, [38:7] top_key, [70:39] removed_key
   logic [1:0]  rsp_tuser;        // [1:0] status

   binary_min_heap_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow heap: keys and fill as the block should hold them after every
   // accepted request.
   key_type     heap_keys [HEAP_DEPTH];
   int unsigned heap_fill = 0;

   // Answers the block still owes, oldest first.
   rsp_type pending_answers [$];

   int requests_sent = 0;
   int answers_seen = 0;
   int mismatch_count = 0;
   int full_rejects = 0;
   int range_rejects = 0;
   int deletes_done = 0;
   int peak_fill = 0;

   // pacing controls shared between the test tasks and the response-side process
   bit send_quiet = 1'b0;
   bit take_quiet = 1'b0;
   int rsp_hold_left = 0;
   int rsp_stall_left = 0;

   // Idle stretch length: mostly short, now and then a long one.
   function automatic int pick_stretch();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Move the key at slot toward the leaves while a child is strictly smaller;
   // the left child wins a tie.
   function automatic void sink_key(int unsigned slot);
      int unsigned left, right, pick;
      key_type     held;
      while (slot < heap_fill) begin
         left  = 2 * slot + 1;
         right = 2 * slot + 2;
         if (left >= heap_fill)
            break;
         pick = left;
         if (right < heap_fill && heap_keys[right] < heap_keys[left])
            pick = right;
         if (!(heap_keys[pick] < heap_keys[slot]))
            break;
         held             = heap_keys[slot];
         heap_keys[slot]  = heap_keys[pick];
         heap_keys[pick]  = held;
         slot             = pick;
      end
   endfunction

   // Move the key at slot toward the root while it is strictly below its parent.
   function automatic void float_key(int unsigned slot);
      int unsigned parent;
      key_type     held;
      while (slot > 0 && slot < heap_fill) begin
         parent = (slot - 1) / 2;
         if (!(heap_keys[slot] < heap_keys[parent]))
            break;
         held               = heap_keys[slot];
         heap_keys[slot]    = heap_keys[parent];
         heap_keys[parent]  = held;
         slot               = parent;
      end
   endfunction

   // Run one heap operation on the shadow heap and return the answer it earns.
   function automatic rsp_type apply_heap_op(logic [2:0] op, key_type key, idx_type slot);
      rsp_type     answer;
      int unsigned walk;
      answer        = '0;
      answer.status = STAT_OK;
      case (op)
         KIND_APPEND, KIND_INSERT: begin
            if (heap_fill >= HEAP_DEPTH) begin
               answer.status = STAT_FULL;
            end else begin
               heap_keys[heap_fill] = key;
               heap_fill++;
               if (op == KIND_INSERT)
                  float_key(heap_fill - 1);
            end
         end
         KIND_BUILD: begin
            if (heap_fill >= 2) begin
               walk = (heap_fill - 2) / 2 + 1;
               while (walk > 0) begin
                  walk--;
                  sink_key(walk);
               end
            end
         end
         KIND_DELETE: begin
            if (slot >= heap_fill) begin
               answer.status = STAT_RANGE;
            end else begin
               answer.removed_key = heap_keys[slot];
               heap_fill--;
               // the last key fills the hole and may have to go either way
               if (slot < heap_fill) begin
                  heap_keys[slot] = heap_keys[heap_fill];
                  sink_key(slot);
                  float_key(slot);
               end
            end
         end
         KIND_INCREASE, KIND_DECREASE: begin
            if (slot >= heap_fill) begin
               answer.status = STAT_RANGE;
            end else begin
               heap_keys[slot] = key;
               if (op == KIND_INCREASE)
                  sink_key(slot);
               else
                  float_key(slot);
            end
         end
         default: ;
      endcase
      answer.heap_count = cnt_type'(heap_fill);
      answer.top_key    = (heap_fill > 0) ? heap_keys[0] : '0;
      return answer;
   endfunction

   // Offer one request after an optional idle gap and hold it until accepted.
   // Returns at the accepting edge with valid still high, so a back-to-back
   // request needs only one assignment in that step.
   task automatic push_request(input logic [2:0] op, input key_type key, input idx_type slot);
      int      gap;
      rsp_type answer;
      gap = (send_quiet || $urandom_range(0, 1) == 0) ? 0 : pick_stretch();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, slot, key};
      req_tuser  <= op;
      do
         @(posedge clock);
      while (!req_tready);
      answer = apply_heap_op(op, key, slot);
      pending_answers.insert(pending_answers.size(), answer);
      requests_sent++;
      if (answer.status == STAT_FULL)
         full_rejects++;
      if (answer.status == STAT_RANGE)
         range_rejects++;
      if (op == KIND_DELETE && answer.status == STAT_OK)
         deletes_done++;
      if (heap_fill > peak_fill)
         peak_fill = heap_fill;
   endtask

   function automatic key_type random_key();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         return key_type'($urandom);
      if (pick < 9)
         // narrow range: plenty of ties and sign changes
         return key_type'(int'($urandom_range(0, 15)) - 8);
      case ($urandom_range(0, 3))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return -32'sd1;
         default: return 32'sd0;
      endcase
   endfunction

   // a slot the heap holds, or any slot when it is empty
   function automatic idx_type held_slot();
      if (heap_fill == 0)
         return idx_type'($urandom_range(0, HEAP_DEPTH - 1));
      return idx_type'($urandom_range(0, heap_fill - 1));
   endfunction

   function automatic idx_type random_slot();
      return idx_type'($urandom_range(0, HEAP_DEPTH - 1));
   endfunction

   // One random operation, mostly on slots that exist.
   task automatic push_random_op();
      int         pick;
      logic [2:0] op;
      idx_type    slot;
      pick = $urandom_range(0, 99);
      slot = held_slot();
      if (pick < 25)
         op = KIND_DELETE;
      else if (pick < 45)
         op = KIND_INCREASE;
      else if (pick < 65)
         op = KIND_DECREASE;
      else if (pick < 80)
         op = KIND_INSERT;
      else if (pick < 86)
         op = KIND_APPEND;
      else if (pick < 89)
         op = KIND_BUILD;
      else if (pick < 91)
         op = ($urandom_range(0, 1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
      else begin
         // slot past the end of the heap, unless the heap is full
         case ($urandom_range(0, 2))
            0:       op = KIND_DELETE;
            1:       op = KIND_INCREASE;
            default: op = KIND_DECREASE;
         endcase
         if (heap_fill < HEAP_DEPTH)
            slot = idx_type'($urandom_range(heap_fill, HEAP_DEPTH - 1));
      end
      if (op == KIND_BUILD || op == KIND_SPARE_LO || op == KIND_SPARE_HI ||
          op == KIND_APPEND || op == KIND_INSERT)
         slot = random_slot();
      push_request(op, random_key(), slot);
   endtask

   // Empty heap rejections, spare kinds, key extremes, ties, delete of root,
   // inner and last slot, and a delete where the moved key must rise.
   task automatic test_directed_corners();
      push_request(KIND_DELETE, 32'sd0, 6'd0);
      push_request(KIND_INCREASE, 32'sd5, 6'd0);
      push_request(KIND_DECREASE, -32'sd5, 6'd63);
      push_request(KIND_BUILD, 32'sd0, 6'd0);
      push_request(KIND_SPARE_LO, 32'sh5A5A_A5A5, 6'd42);
      push_request(KIND_SPARE_HI, 32'shA5A5_5A5A, 6'd21);
      push_request(KIND_APPEND, 32'sh7FFF_FFFF, 6'd0);
      push_request(KIND_BUILD, 32'sd0, 6'd0);
      push_request(KIND_DELETE, 32'sd0, 6'd1);
      push_request(KIND_INSERT, 32'sh8000_0000, 6'd0);
      push_request(KIND_INSERT, 32'sh7FFF_FFFF, 6'd0);
      push_request(KIND_INSERT, -32'sd1, 6'd0);
      push_request(KIND_DECREASE, 32'sh8000_0000, 6'd3);
      push_request(KIND_INCREASE, 32'sh7FFF_FFFF, 6'd0);
      push_request(KIND_APPEND, -32'sd6, 6'd0);
      push_request(KIND_APPEND, -32'sd7, 6'd0);
      push_request(KIND_BUILD, 32'sd0, 6'd0);
      push_request(KIND_SPARE_HI, 32'sd1, 6'd1);
      push_request(KIND_DELETE, 32'sd0, 6'd5);
      push_request(KIND_DELETE, 32'sd0, 6'd0);
      push_request(KIND_DELETE, 32'sd0, 6'd1);
      while (heap_fill > 0)
         push_request(KIND_DELETE, 32'sd0, 6'd0);
      // builds 0,10,1,11,12,2,3; removing slot 3 pulls 3 in under 10, so it rises
      push_request(KIND_INSERT, 32'sd0, 6'd0);
      push_request(KIND_INSERT, 32'sd10, 6'd0);
      push_request(KIND_INSERT, 32'sd1, 6'd0);
      push_request(KIND_INSERT, 32'sd11, 6'd0);
      push_request(KIND_INSERT, 32'sd12, 6'd0);
      push_request(KIND_INSERT, 32'sd2, 6'd0);
      push_request(KIND_INSERT, 32'sd3, 6'd0);
      push_request(KIND_DELETE, 32'sd0, 6'd3);
   endtask

   // Fill the store raw, hit the full limit, build it, then work on the top slot.
   task automatic test_store_full();
      while (heap_fill < HEAP_DEPTH)
         push_request(KIND_APPEND, random_key(), random_slot());
      push_request(KIND_APPEND, random_key(), random_slot());
      push_request(KIND_INSERT, random_key(), random_slot());
      push_request(KIND_BUILD, random_key(), random_slot());
      push_request(KIND_DECREASE, 32'sh8000_0000, 6'd63);
      push_request(KIND_INCREASE, 32'sh7FFF_FFFF, 6'd0);
      push_request(KIND_DELETE, 32'sd0, 6'd63);
      push_request(KIND_INSERT, random_key(), random_slot());
      push_request(KIND_DELETE, 32'sd0, 6'd62);
      repeat (20)
         push_random_op();
   endtask

   // Stop taking answers for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      send_quiet    = 1'b1;
      rsp_hold_left = HOLD_CYCLES;
      repeat (10)
         push_request(KIND_INSERT, random_key(), random_slot());
      repeat (6)
         push_random_op();
      send_quiet = 1'b0;
   endtask

   // Episodes: grow the heap (by insert, or raw and then mostly built), work on it,
   // sometimes drain it. Some episodes run with no idling on either side.
   task automatic test_random_episodes();
      int target;
      bit raw_fill;
      while (requests_sent < REQUEST_GOAL) begin
         send_quiet = ($urandom_range(0, 99) < 15);
         take_quiet = send_quiet;
         target     = ($urandom_range(0, 9) == 0) ? HEAP_DEPTH : $urandom_range(1, 24);
         raw_fill   = ($urandom_range(0, 2) == 0);
         while (heap_fill < target)
            push_request(raw_fill ? KIND_APPEND : KIND_INSERT, random_key(), random_slot());
         if (raw_fill && $urandom_range(0, 3) != 0)
            push_request(KIND_BUILD, random_key(), random_slot());
         repeat ($urandom_range(10, 40))
            push_random_op();
         if ($urandom_range(0, 3) == 0) begin
            while (heap_fill > 0)
               push_request(KIND_DELETE, random_key(),
                            ($urandom_range(0, 1) == 0) ? idx_type'(0) : held_slot());
            push_request(KIND_DELETE, random_key(), random_slot());
         end
      end
      send_quiet = 1'b0;
      take_quiet = 1'b0;
   endtask

   // Response side pacing: a requested hold first, then random stalls.
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready    <= 1'b0;
         rsp_hold_left  = rsp_hold_left - 1;
      end else if (rsp_stall_left > 0 && !take_quiet) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left  = rsp_stall_left - 1;
      end else begin
         rsp_tready     <= 1'b1;
         rsp_stall_left  = 0;
         if (!take_quiet && $urandom_range(0, 99) < 30)
            rsp_stall_left = pick_stretch();
      end
   end

   function automatic void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at %0t ns, answer %0d: %s expected %h got %h",
                  $time, answers_seen, field, want, got);
   endfunction

   // Compare each answer taken against the oldest one owed.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            flag_mismatch("answer with no request outstanding, tuser", '0, rsp_tuser);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tuser !== want.status)
               flag_mismatch("status", want.status, rsp_tuser);
            if (rsp_tdata[6:0] !== want.heap_count)
               flag_mismatch("heap_count", want.heap_count, rsp_tdata[6:0]);
            if (rsp_tdata[38:7] !== want.top_key)
               flag_mismatch("top_key", want.top_key, rsp_tdata[38:7]);
            if (rsp_tdata[70:39] !== want.removed_key)
               flag_mismatch("removed_key", want.removed_key, rsp_tdata[70:39]);
         end
         answers_seen++;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_store_full();
      test_output_backpressure();
      test_random_episodes();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d requests and %0d answers, peak fill %0d, %0d deletes",
               requests_sent, answers_seen, peak_fill, deletes_done);
      $display("rejections seen: %0d store full, %0d slot out of range; %0d mismatches",
               full_rejects, range_rejects, mismatch_count);
      if (mismatch_count == 0 && pending_answers.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("timeout with %0d answers outstanding", pending_answers.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
